// ===== src/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants shared by the rate-monotonic task scheduler modules.
// ----------------------------------------------------------------------------
package rmts_pkg;

   localparam int unsigned UTIL_SCALE = 1000000;
   localparam logic [19:0] UTIL_LIMIT_RESET = 20'd693000;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_YIELD      = 2'd1,
      OP_DEREGISTER = 2'd2,
      OP_WAKEUP     = 2'd3
   } opcode_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_MISSED   = 3'd4;
   localparam logic [2:0] ST_ZERO_PER = 3'd5;

   localparam logic [1:0] RS_SLEEP = 2'd0;
   localparam logic [1:0] RS_READY = 2'd1;
   localparam logic [1:0] RS_RUN   = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [21:0] task_id;
      logic [15:0] period_ticks;
      logic [15:0] runtime_ticks;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        run_valid;
      logic [21:0] run_task_id;
      logic        preempt_valid;
      logic [21:0] preempt_task_id;
      logic        timer_valid;
      logic [31:0] timer_deadline;
      logic [19:0] total_utilization;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, start multiply
      logic div_start;
      logic scan_start;
      logic execute;   // apply event, start dispatch scan
      logic commit;    // apply dispatch, build response
      logic reply;     // latch run fields of the response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic scan_done;
   } sts_type;

endpackage

// ===== src/rmts_datapath.sv =====
// ----------------------------------------------------------------------------
// rmts_datapath
// Slot table, serial utilization divider, slot scans and dispatch.
// ----------------------------------------------------------------------------
module rmts_datapath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rmts_pkg::cmd_type   cmd,
   output rmts_pkg::sts_type   sts,
   input  rmts_pkg::req_type   req,
   input  logic [19:0]         util_limit,
   output rmts_pkg::rsp_type   rsp
);
   import rmts_pkg::*;

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [MAX_TASKS-1:0] valid_ff;
   logic [21:0] id_ff [MAX_TASKS];
   logic [15:0] per_ff [MAX_TASKS];
   logic [19:0] util_ff [MAX_TASKS];
   logic [31:0] dl_ff [MAX_TASKS];
   logic [1:0]  rs_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] started_ff;

   logic        cur_valid_ff;
   logic [SW-1:0] cur_slot_ff;
   logic [19:0] sum_ff;
   req_type     req_ff;
   rsp_type     rsp_ff;

   // divider: 36-bit numerator / 16-bit divisor, one quotient bit per cycle
   logic [35:0] num_ff;
   logic [16:0] rem_ff;
   logic [5:0]  div_cnt_ff;
   logic        div_busy_ff;
   logic [16:0] rem_shift;

   // scan over slots
   logic [CW-1:0] scan_ff;
   logic          scan_busy_ff;
   logic          scan_dispatch_ff;
   logic          found_ff, free_ok_ff, best_ok_ff;
   logic [SW-1:0] found_slot_ff, free_slot_ff, best_slot_ff;
   logic [SW-1:0] scan_idx;
   logic          dispatch_ff;
   logic [2:0]    status_ff;
   logic          timer_v_ff;
   logic [31:0]   timer_d_ff;

   logic [31:0] new_dl;
   logic [19:0] util_q;
   logic [36:0] admit_sum;
   logic        run_ok;

   assign scan_idx = scan_ff[SW-1:0];
   assign util_q   = num_ff[19:0];
   assign rem_shift = {rem_ff[15:0], num_ff[35]};
   assign admit_sum = {17'd0, sum_ff} + {1'b0, num_ff};
   assign new_dl = started_ff[found_slot_ff]
                   ? dl_ff[found_slot_ff] + {16'd0, per_ff[found_slot_ff]}
                   : req_ff.now_ms + {16'd0, per_ff[found_slot_ff]};

   assign sts.div_done  = div_busy_ff && (div_cnt_ff == 6'd0);
   assign sts.scan_done = scan_busy_ff && (scan_ff == CW'(MAX_TASKS));

   // run fields follow the committed selection
   assign run_ok = cur_valid_ff && valid_ff[cur_slot_ff] && rs_ff[cur_slot_ff] == RS_RUN;
   assign rsp    = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         sum_ff       <= '0;
         div_busy_ff  <= 1'b0;
         scan_busy_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            req_ff <= req;
            num_ff <= 36'(req.runtime_ticks) * 36'(UTIL_SCALE);
         end
         if (cmd.div_start) begin
            rem_ff      <= '0;
            div_cnt_ff  <= 6'd36;
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff != 6'd0) begin
            if (rem_shift >= {1'b0, req_ff.period_ticks}) begin
               rem_ff <= rem_shift - {1'b0, req_ff.period_ticks};
               num_ff <= {num_ff[34:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               num_ff <= {num_ff[34:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff - 6'd1;
         end else if (div_busy_ff) begin
            div_busy_ff <= 1'b0;
         end

         if (cmd.scan_start || cmd.execute) begin
            scan_ff          <= '0;
            scan_busy_ff     <= 1'b1;
            scan_dispatch_ff <= cmd.execute;
            found_ff         <= 1'b0;
            free_ok_ff       <= 1'b0;
            best_ok_ff       <= 1'b0;
         end else if (scan_busy_ff && scan_ff != CW'(MAX_TASKS)) begin
            if (!scan_dispatch_ff) begin
               if (valid_ff[scan_idx] && id_ff[scan_idx] == req_ff.task_id && !found_ff) begin
                  found_ff      <= 1'b1;
                  found_slot_ff <= scan_idx;
               end
               if (!valid_ff[scan_idx] && !free_ok_ff) begin
                  free_ok_ff   <= 1'b1;
                  free_slot_ff <= scan_idx;
               end
            end else if (valid_ff[scan_idx] && rs_ff[scan_idx] == RS_READY &&
                         (!best_ok_ff || per_ff[scan_idx] < per_ff[best_slot_ff])) begin
               best_ok_ff   <= 1'b1;
               best_slot_ff <= scan_idx;
            end
            scan_ff <= scan_ff + CW'(1);
         end else if (scan_busy_ff) begin
            scan_busy_ff <= 1'b0;
         end

         if (cmd.execute) begin
            status_ff   <= ST_OK;
            timer_v_ff  <= 1'b0;
            timer_d_ff  <= '0;
            dispatch_ff <= 1'b0;
            if (req_ff.opcode == OP_REGISTER) begin
               if (req_ff.period_ticks == 16'd0) begin
                  status_ff <= ST_ZERO_PER;
               end else if (admit_sum > {17'd0, util_limit}) begin
                  status_ff <= ST_REJECTED;
               end else if (!free_ok_ff) begin
                  status_ff <= ST_FULL;
               end else begin
                  valid_ff[free_slot_ff]   <= 1'b1;
                  id_ff[free_slot_ff]      <= req_ff.task_id;
                  per_ff[free_slot_ff]     <= req_ff.period_ticks;
                  util_ff[free_slot_ff]    <= util_q;
                  dl_ff[free_slot_ff]      <= '0;
                  rs_ff[free_slot_ff]      <= RS_SLEEP;
                  started_ff[free_slot_ff] <= 1'b0;
                  sum_ff                   <= admit_sum[19:0];
               end
            end else if (!found_ff) begin
               status_ff <= ST_UNKNOWN;
            end else begin
               case (opcode_type'(req_ff.opcode))
                  OP_YIELD: begin
                     dl_ff[found_slot_ff]      <= new_dl;
                     started_ff[found_slot_ff] <= 1'b1;
                     if (new_dl < req_ff.now_ms) begin
                        status_ff <= ST_MISSED;
                     end else begin
                        timer_v_ff <= 1'b1;
                        timer_d_ff <= new_dl;
                        rs_ff[found_slot_ff] <= RS_SLEEP;
                        dispatch_ff <= 1'b1;
                     end
                  end
                  OP_DEREGISTER: begin
                     valid_ff[found_slot_ff] <= 1'b0;
                     rs_ff[found_slot_ff]    <= RS_SLEEP;
                     sum_ff <= sum_ff - util_ff[found_slot_ff];
                     if (cur_valid_ff && cur_slot_ff == found_slot_ff) begin
                        cur_valid_ff <= 1'b0;
                        dispatch_ff  <= 1'b1;
                     end
                  end
                  OP_WAKEUP: begin
                     rs_ff[found_slot_ff] <= RS_READY;
                     dispatch_ff <= 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         if (cmd.commit) begin
            rsp_ff.preempt_valid   <= 1'b0;
            rsp_ff.preempt_task_id <= '0;
            if (dispatch_ff && best_ok_ff) begin
               if (cur_valid_ff && valid_ff[cur_slot_ff] && rs_ff[cur_slot_ff] == RS_RUN) begin
                  if (per_ff[cur_slot_ff] > per_ff[best_slot_ff]) begin
                     rs_ff[cur_slot_ff]     <= RS_READY;
                     rs_ff[best_slot_ff]    <= RS_RUN;
                     cur_slot_ff            <= best_slot_ff;
                     rsp_ff.preempt_valid   <= 1'b1;
                     rsp_ff.preempt_task_id <= id_ff[cur_slot_ff];
                  end
               end else begin
                  rs_ff[best_slot_ff] <= RS_RUN;
                  cur_slot_ff         <= best_slot_ff;
                  cur_valid_ff        <= 1'b1;
               end
            end
            rsp_ff.status            <= status_ff;
            rsp_ff.timer_valid       <= timer_v_ff;
            rsp_ff.timer_deadline    <= timer_d_ff;
            rsp_ff.total_utilization <= sum_ff;
         end

         if (cmd.reply) begin
            rsp_ff.run_valid   <= run_ok;
            rsp_ff.run_task_id <= run_ok ? id_ff[cur_slot_ff] : '0;
         end
      end
   end

endmodule

// ===== src/rmts_controller.sv =====
// ----------------------------------------------------------------------------
// rmts_controller
// Sequences one transaction: capture, divide, scan, execute, dispatch, reply.
// ----------------------------------------------------------------------------
module rmts_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmts_pkg::cmd_type cmd,
   input  rmts_pkg::sts_type sts
);
   import rmts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SCAN, S_EXEC, S_DISP, S_COMMIT, S_RESP
   } state_type;

   state_type state_ff;
   logic      req_acc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      cmd.load       = req_acc;
      cmd.div_start  = req_acc;
      cmd.scan_start = (state_ff == S_DIV) && sts.div_done;
      cmd.execute    = (state_ff == S_SCAN) && sts.scan_done;
      cmd.commit     = (state_ff == S_DISP) && sts.scan_done;
      cmd.reply      = (state_ff == S_COMMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:   if (req_acc) state_ff <= S_DIV;
            S_DIV:    if (sts.div_done) state_ff <= S_SCAN;
            S_SCAN:   if (sts.scan_done) state_ff <= S_DISP;
            S_EXEC:   state_ff <= S_DISP;
            S_DISP:   if (sts.scan_done) state_ff <= S_COMMIT;
            S_COMMIT: state_ff <= S_RESP;
            S_RESP:   if (!rsp_stall) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/rate_monotonic_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Serves one request at a time: a 36-step serial divider, then a lookup scan
// and a dispatch scan over the slots. The next request is taken after the
// reply. Reset (synchronous): slot table empty, no current task, sum zero,
// limit 693000.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmts_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [19:0]       csr_data
);
   import rmts_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [19:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= UTIL_LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_data;
      end
   end

   rmts_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd, .sts
   );

   rmts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock, .reset, .cmd, .sts, .req(req_data), .util_limit(limit_ff), .rsp(rsp_data)
   );

endmodule

// ===== src/rmts_checker.sv =====
// ----------------------------------------------------------------------------
// rmts_checker
// Port-level checks on the scheduler's handshakes and results.
// ----------------------------------------------------------------------------
module rmts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rmts_pkg::rsp_type rsp_data
);
   import rmts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with reply pending");

   a_timer_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timer_valid |-> rsp_data.status == ST_OK)
      else $error("timer with error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_ZERO_PER)
      else $error("bad status");

endmodule

bind rate_monotonic_task_scheduler rmts_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rate-monotonic task scheduler. A directed
// table covers admission, table full, unknown tasks, missed deadlines and
// preemption, then random event streams on a small pool of task ids are
// checked against a behavioral task table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import rmts_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [19:0] csr_data = '0;

   always #1 clock = ~clock;

   rate_monotonic_task_scheduler #(.MAX_TASKS(NSLOT)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   // scheduler table mirror
   logic [19:0] util_limit;
   logic        tbl_valid [NSLOT];
   logic [21:0] tbl_id [NSLOT];
   logic [15:0] tbl_period [NSLOT];
   logic [19:0] tbl_util [NSLOT];
   logic [31:0] tbl_deadline [NSLOT];
   logic [1:0]  tbl_state [NSLOT];
   logic        tbl_started [NSLOT];
   logic        cur_valid;
   int          cur_slot;
   logic [19:0] util_sum;

   rsp_type expected_rsps [$];
   int  errors = 0;
   int  cycles = 0;
   bit  no_idle = 1'b0;

   function automatic int lookup_task(logic [21:0] id);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int pick_next();
      int best;
      int pre;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_state[i] == RS_READY &&
             (best < 0 || tbl_period[i] < tbl_period[best]))
            best = i;
      if (best < 0) return -1;
      if (cur_valid && tbl_valid[cur_slot] && tbl_state[cur_slot] == RS_RUN) begin
         if (tbl_period[cur_slot] <= tbl_period[best]) return -1;
         tbl_state[cur_slot] = RS_READY;
         tbl_state[best] = RS_RUN;
         pre = cur_slot;
         cur_slot = best;
         return pre;
      end
      tbl_state[best] = RS_RUN;
      cur_slot = best;
      cur_valid = 1'b1;
      return -1;
   endfunction

   function automatic rsp_type schedule_event(req_type r);
      rsp_type o;
      int s;
      int f;
      int pre;
      logic [63:0] u;
      o = '0;
      pre = -1;
      o.status = ST_OK;
      if (r.opcode == OP_REGISTER) begin
         if (r.period_ticks == 0) o.status = ST_ZERO_PER;
         else begin
            u = (64'(r.runtime_ticks) * UTIL_SCALE) / r.period_ticks;
            if (64'(util_sum) + u > 64'(util_limit)) o.status = ST_REJECTED;
            else begin
               f = -1;
               for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) f = i;
               if (f < 0) o.status = ST_FULL;
               else begin
                  tbl_valid[f] = 1'b1;
                  tbl_id[f] = r.task_id;
                  tbl_period[f] = r.period_ticks;
                  tbl_util[f] = u[19:0];
                  tbl_deadline[f] = '0;
                  tbl_state[f] = RS_SLEEP;
                  tbl_started[f] = 1'b0;
                  util_sum = util_sum + u[19:0];
               end
            end
         end
      end else begin
         s = lookup_task(r.task_id);
         if (s < 0) o.status = ST_UNKNOWN;
         else if (r.opcode == OP_YIELD) begin
            if (!tbl_started[s]) begin
               tbl_deadline[s] = tbl_deadline[s] + r.now_ms + 32'(tbl_period[s]);
               tbl_started[s] = 1'b1;
            end else
               tbl_deadline[s] = tbl_deadline[s] + 32'(tbl_period[s]);
            if (tbl_deadline[s] < r.now_ms) o.status = ST_MISSED;
            else begin
               o.timer_valid = 1'b1;
               o.timer_deadline = tbl_deadline[s];
               tbl_state[s] = RS_SLEEP;
               pre = pick_next();
            end
         end else if (r.opcode == OP_DEREGISTER) begin
            tbl_valid[s] = 1'b0;
            tbl_state[s] = RS_SLEEP;
            util_sum = util_sum - tbl_util[s];
            if (cur_valid && cur_slot == s) begin
               cur_valid = 1'b0;
               pre = pick_next();
            end
         end else begin
            tbl_state[s] = RS_READY;
            pre = pick_next();
         end
      end
      if (cur_valid && tbl_valid[cur_slot] && tbl_state[cur_slot] == RS_RUN) begin
         o.run_valid = 1'b1;
         o.run_task_id = tbl_id[cur_slot];
      end
      if (pre >= 0) begin
         o.preempt_valid = 1'b1;
         o.preempt_task_id = tbl_id[pre];
      end
      o.total_utilization = util_sum;
      return o;
   endfunction

   // drives at falling edges; valid may rise again in the step that lowered it
   task automatic drive_event(req_type r, rsp_type e);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      expected_rsps.push_back(e);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_event(req_type r);
      drive_event(r, schedule_event(r));
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [19:0] v);
      csr_data <= v;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      util_limit = v;
   endtask

   // receiver
   always @(negedge clock)
      rsp_stall <= !no_idle && ($urandom_range(99) < 25);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_data);
            errors <= errors + 1;
         end else begin
            if (rsp_data !== expected_rsps[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time,
                        expected_rsps[0], rsp_data);
               errors <= errors + 1;
            end
            void'(expected_rsps.pop_front());
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   typedef struct {
      req_type r;
      bit      has_exp;
      logic [2:0]  status;
      logic [19:0] total;
   } vector_type;

   function automatic req_type mk(opcode_type op, logic [21:0] id, logic [15:0] p,
                                  logic [15:0] rt, logic [31:0] now);
      req_type r;
      r.opcode = op; r.task_id = id; r.period_ticks = p;
      r.runtime_ticks = rt; r.now_ms = now;
      return r;
   endfunction

   function automatic req_type random_event();
      req_type r;
      int k;
      r.opcode = opcode_type'($urandom_range(3));
      r.task_id = ($urandom_range(9) == 0) ? 22'($urandom) : 22'($urandom_range(11));
      k = $urandom_range(9);
      r.period_ticks = (k == 0) ? 16'($urandom) : (k == 1) ? 16'd0
                                                           : 16'($urandom_range(1, 200));
      r.runtime_ticks = (k == 2) ? 16'($urandom) : 16'($urandom_range(0, 20));
      r.now_ms = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 5000));
      if (r.opcode == OP_REGISTER && $urandom_range(3) == 0) r.opcode = OP_WAKEUP;
      return r;
   endfunction

   initial begin
      vector_type dir [$];
      rsp_type    got;
      logic [19:0] limits [4];
      util_limit = UTIL_LIMIT_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 0; tbl_id[i] = 0; tbl_period[i] = 0; tbl_util[i] = 0;
         tbl_deadline[i] = 0; tbl_state[i] = RS_SLEEP; tbl_started[i] = 0;
      end
      cur_valid = 0; cur_slot = 0; util_sum = 0;

      dir.push_back('{mk(OP_YIELD, 22'd5, 0, 0, 0), 1, ST_UNKNOWN, 20'd0});
      dir.push_back('{mk(OP_REGISTER, 22'd1, 0, 5, 0), 1, ST_ZERO_PER, 20'd0});
      dir.push_back('{mk(OP_REGISTER, 22'd1, 16'hFFFF, 16'hFFFF, 0), 1, ST_REJECTED, 20'd0});
      dir.push_back('{mk(OP_REGISTER, 22'h3FFFFF, 16'd100, 16'd10, 0), 1, ST_OK, 20'd100000});
      dir.push_back('{mk(OP_REGISTER, 22'd2, 16'd50, 16'd5, 0), 1, ST_OK, 20'd200000});
      dir.push_back('{mk(OP_REGISTER, 22'd3, 16'hFFFF, 16'd0, 0), 1, ST_OK, 20'd200000});
      dir.push_back('{mk(OP_WAKEUP, 22'h3FFFFF, 0, 0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_WAKEUP, 22'd2, 0, 0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_YIELD, 22'd2, 0, 0, 32'd1000), 0, 0, 0});
      dir.push_back('{mk(OP_YIELD, 22'd2, 0, 0, 32'd5000), 1, ST_MISSED, 20'd200000});
      dir.push_back('{mk(OP_YIELD, 22'd3, 0, 0, 32'hFFFFFFFF), 1, ST_MISSED, 20'd200000});
      dir.push_back('{mk(OP_WAKEUP, 22'd3, 0, 0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_WAKEUP, 22'd2, 0, 0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_DEREGISTER, 22'd2, 0, 0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_DEREGISTER, 22'd9, 0, 0, 0), 1, ST_UNKNOWN, 20'd100000});
      for (int i = 0; i < 15; i++)
         dir.push_back('{mk(OP_REGISTER, 22'd7, 16'd1000, 16'd0, 0), 0, 0, 0});
      dir.push_back('{mk(OP_REGISTER, 22'd8, 16'd1, 16'd0, 0), 1, ST_FULL, 20'd100000});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir[i]) begin
         if (dir[i].has_exp) begin
            got = schedule_event(dir[i].r);
            if (got.status !== dir[i].status || got.total_utilization !== dir[i].total)
               begin
               $display("%0t: mismatch expected %0d/%0d actual %0d/%0d", $time,
                        dir[i].status, dir[i].total, got.status, got.total_utilization);
               errors++;
            end
            drive_event(dir[i].r, got);
         end else
            send_event(dir[i].r);
      end
      wait_drained();

      limits = '{20'd0, 20'd1000000, 20'hFFFFF, 20'd500000};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 4) write_limit(limits[ph]);
         else write_limit(20'($urandom_range(1000000)));
         no_idle = (ph == 2);
         for (int n = 0; n < 225; n++) begin
            send_event(random_event());
            if (n == 120 && ph == 1) wait_drained();
         end
         wait_drained();
         for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i]) send_event(mk(OP_DEREGISTER, tbl_id[i], 0, 0, 0));
         wait_drained();
      end
      no_idle = 1'b0;

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
